### design/bpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpd_pkg: shared types, constants and keyword tables
// Event codes, controller/datapath command and status, keyword ROM lookups.
// ----------------------------------------------------------------------------
package bpd_pkg;

  localparam logic [2:0] EV_CHAR    = 3'd0;
  localparam logic [2:0] EV_EOL     = 3'd1;
  localparam logic [2:0] EV_END     = 3'd2;
  localparam logic [2:0] EV_BADADDR = 3'd3;
  localparam logic [2:0] EV_NONE    = 3'd4;

  localparam logic [7:0]  ESC_BYTE  = 8'h64;
  localparam logic [7:0]  EXT_FIRST = 8'h01;
  localparam logic [7:0]  EXT_LAST  = 8'h7C;
  localparam logic [7:0]  STD_FIRST = 8'h80;
  localparam logic [7:0]  STD_LAST  = 8'hCB;
  localparam logic [15:0] LOAD_ADDR = 16'h0801;
  localparam int          MAX_CHARS = 8;

  // What the datapath should emit for the current byte
  typedef enum logic [2:0] {
    SRC_NONE,    // one event, no text
    SRC_CHAR,    // single character = the byte
    SRC_STD,     // standard keyword
    SRC_EXT,     // extension keyword
    SRC_NUM      // decimal line number + space
  } src_t;

  typedef struct packed {
    logic        load;     // start a new emission
    src_t        src;
    logic [2:0]  ev;       // event for SRC_NONE
    logic [7:0]  byte_v;
    logic [15:0] num;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;            // emission in progress
  } dp_sts_t;

  // Keyword text packed as up to 8 characters, first char in lowest byte.
  function automatic logic [63:0] str8(input string s);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < s.len() && i < 8; i++) r[i*8 +: 8] = s[i];
    return r;
  endfunction

  function automatic logic [63:0] std_word(input logic [6:0] i);
    logic [63:0] r;
    case (i)
      7'd0: r = str8("END");     7'd1: r = str8("FOR");     7'd2: r = str8("NEXT");
      7'd3: r = str8("DATA");    7'd4: r = str8("INPUT#");  7'd5: r = str8("INPUT");
      7'd6: r = str8("DIM");     7'd7: r = str8("READ");    7'd8: r = str8("LET");
      7'd9: r = str8("GOTO");    7'd10: r = str8("RUN");    7'd11: r = str8("IF");
      7'd12: r = str8("RESTORE"); 7'd13: r = str8("GOSUB"); 7'd14: r = str8("RETURN");
      7'd15: r = str8("REM");    7'd16: r = str8("STOP");   7'd17: r = str8("ON");
      7'd18: r = str8("WAIT");   7'd19: r = str8("LOAD");   7'd20: r = str8("SAVE");
      7'd21: r = str8("VERIFY"); 7'd22: r = str8("DEF");    7'd23: r = str8("POKE");
      7'd24: r = str8("PRINT#"); 7'd25: r = str8("PRINT");  7'd26: r = str8("CONT");
      7'd27: r = str8("LIST");   7'd28: r = str8("CLR");    7'd29: r = str8("CMD");
      7'd30: r = str8("SYS");    7'd31: r = str8("OPEN");   7'd32: r = str8("CLOSE");
      7'd33: r = str8("GET");    7'd34: r = str8("NEW");    7'd35: r = str8("TAB(");
      7'd36: r = str8("TO");     7'd37: r = str8("FN");     7'd38: r = str8("SPC(");
      7'd39: r = str8("THEN");   7'd40: r = str8("NOT");    7'd41: r = str8("STEP");
      7'd42: r = str8("+");      7'd43: r = str8("-");      7'd44: r = str8("*");
      7'd45: r = str8("/");      7'd46: r = str8("^");      7'd47: r = str8("AND");
      7'd48: r = str8("OR");     7'd49: r = str8(">");      7'd50: r = str8("=");
      7'd51: r = str8("<");      7'd52: r = str8("SGN");    7'd53: r = str8("INT");
      7'd54: r = str8("ABS");    7'd55: r = str8("USR");    7'd56: r = str8("FRE");
      7'd57: r = str8("POS");    7'd58: r = str8("SQR");    7'd59: r = str8("RND");
      7'd60: r = str8("LOG");    7'd61: r = str8("EXP");    7'd62: r = str8("COS");
      7'd63: r = str8("SIN");    7'd64: r = str8("TAN");    7'd65: r = str8("ATN");
      7'd66: r = str8("PEEK");   7'd67: r = str8("LEN");    7'd68: r = str8("STR$");
      7'd69: r = str8("VAL");    7'd70: r = str8("ASC");    7'd71: r = str8("CHR$");
      7'd72: r = str8("LEFT$");  7'd73: r = str8("RIGHT$"); 7'd74: r = str8("MID$");
      7'd75: r = str8("GO");
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] ext_word(input logic [6:0] i);
    logic [63:0] r;
    case (i)
      7'd0: r = str8("HIRES");   7'd1: r = str8("PLOT");    7'd2: r = str8("LINE");
      7'd3: r = str8("BLOCK");   7'd4: r = str8("FCHR");    7'd5: r = str8("FCOL");
      7'd6: r = str8("FILL");    7'd7: r = str8("RECT");    7'd8: r = str8("ROT");
      7'd9: r = str8("DRAW");    7'd10: r = str8("CHAR");   7'd11: r = str8("HI COL");
      7'd12: r = str8("INV");    7'd13: r = str8("FRAC");   7'd14: r = str8("MOVE");
      7'd15: r = str8("PLACE");  7'd16: r = str8("UPB");    7'd17: r = str8("UPW");
      7'd18: r = str8("LEFTW");  7'd19: r = str8("LEFTB");  7'd20: r = str8("DOWNB");
      7'd21: r = str8("DOWNW");  7'd22: r = str8("RIGHTB"); 7'd23: r = str8("RIGHTW");
      7'd24: r = str8("MULTI");  7'd25: r = str8("COLOUR"); 7'd26: r = str8("MMOB");
      7'd27: r = str8("BFLASH"); 7'd28: r = str8("MOB SET"); 7'd29: r = str8("MUSIC");
      7'd30: r = str8("FLASH");  7'd31: r = str8("REPEAT"); 7'd32: r = str8("PLAY");
      7'd33: r = str8(">>");     7'd34: r = str8("CENTRE"); 7'd35: r = str8("ENVELOPE");
      7'd36: r = str8("CGOTO");  7'd37: r = str8("WAVE");   7'd38: r = str8("FETCH");
      7'd39: r = str8("AT(");    7'd40: r = str8("UNTIL");  7'd41: r = str8(">>");
      7'd42: r = str8(">>");     7'd43: r = str8("USE");    7'd44: r = str8(">>");
      7'd45: r = str8("GLOBAL"); 7'd46: r = str8(">>");     7'd47: r = str8("RESET");
      7'd48: r = str8("PROC");   7'd49: r = str8("CALL");   7'd50: r = str8("EXEC");
      7'd51: r = str8("END PROC"); 7'd52: r = str8("EXIT"); 7'd53: r = str8("END LOOP");
      7'd54: r = str8("ON KEY"); 7'd55: r = str8("DISABLE"); 7'd56: r = str8("RESUME");
      7'd57: r = str8("LOOP");   7'd58: r = str8("DELAY");  7'd59: r = str8(">>");
      7'd60: r = str8(">>");     7'd61: r = str8(">>");     7'd62: r = str8(">>");
      7'd63: r = str8("SECURE"); 7'd64: r = str8("DISAPA"); 7'd65: r = str8("CIRCLE");
      7'd66: r = str8("ON ERROR"); 7'd67: r = str8("NO ERROR"); 7'd68: r = str8("LOCAL");
      7'd69: r = str8("RCOMP");  7'd70: r = str8("ELSE");   7'd71: r = str8("RETRACE");
      7'd72: r = str8("TRACE");  7'd73: r = str8("DIR");    7'd74: r = str8("PAGE");
      7'd75: r = str8("DUMP");   7'd76: r = str8("FIND");   7'd77: r = str8("OPTION");
      7'd78: r = str8("AUTO");   7'd79: r = str8("OLD");    7'd80: r = str8("JOY");
      7'd81: r = str8("MOD");    7'd82: r = str8("DIV");    7'd83: r = str8(">>");
      7'd84: r = str8("DUP");    7'd85: r = str8("INKEY");  7'd86: r = str8("INST");
      7'd87: r = str8("TEST");   7'd88: r = str8("LIN");    7'd89: r = str8("EXOR");
      7'd90: r = str8("INSERT"); 7'd91: r = str8("POT");    7'd92: r = str8("PENX");
      7'd93: r = str8(">>");     7'd94: r = str8("PENY");   7'd95: r = str8("SOUND");
      7'd96: r = str8("GRAPHICS"); 7'd97: r = str8("DESIGN"); 7'd98: r = str8("RLOCMOB");
      7'd99: r = str8("CMOB");   7'd100: r = str8("BCKGNDS"); 7'd101: r = str8("PAUSE");
      7'd102: r = str8("NRM");   7'd103: r = str8("MOB OFF"); 7'd104: r = str8("OFF");
      7'd105: r = str8("ANGL");  7'd106: r = str8("ARC");   7'd107: r = str8("COLD");
      7'd108: r = str8("SCRSV"); 7'd109: r = str8("SCRLD"); 7'd110: r = str8("TEXT");
      7'd111: r = str8("CSET");  7'd112: r = str8("VOL");   7'd113: r = str8("DISK");
      7'd114: r = str8("HRDCPY"); 7'd115: r = str8("KEY");  7'd116: r = str8("PAINT");
      7'd117: r = str8("LOW COL"); 7'd118: r = str8("COPY"); 7'd119: r = str8("MERGE");
      7'd120: r = str8("RENUMBER"); 7'd121: r = str8("MEM"); 7'd122: r = str8("DETECT");
      7'd123: r = str8("CHECK");
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### design/bpd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpd_ctrl: parse controller
// Tracks file position per accepted byte and issues one emit command to the
// datapath; holds off input while the datapath is emitting.
// ----------------------------------------------------------------------------
module bpd_ctrl
  import bpd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       start_req,
  output dp_cmd_t         cmd,
  input  wire dp_sts_t    sts
);

  typedef enum logic [3:0] {
    PH_LOAD_LO, PH_LOAD_HI, PH_LINK_LO, PH_LINK_HI,
    PH_NUM_LO, PH_NUM_HI, PH_BODY, PH_DONE, PH_BAD
  } phase_t;

  phase_t     phase_r, phase_nxt, ph_eff;
  logic [7:0] held_r, held_nxt, held_eff;
  logic       esc_r, esc_nxt, esc_eff;
  logic       acc;

  assign in_ready = !sts.busy;
  assign acc      = in_valid && in_ready;

  always_comb begin
    ph_eff   = start_req ? PH_LOAD_LO : phase_r;
    held_eff = start_req ? 8'd0 : held_r;
    esc_eff  = start_req ? 1'b0 : esc_r;
    phase_nxt = ph_eff;
    held_nxt  = held_eff;
    esc_nxt   = esc_eff;
    cmd.load   = acc;
    cmd.src    = SRC_NONE;
    cmd.ev     = EV_NONE;
    cmd.byte_v = data_byte;
    cmd.num    = {data_byte, held_eff};
    case (ph_eff)
      PH_LOAD_LO: begin
        held_nxt = data_byte; phase_nxt = PH_LOAD_HI;
      end
      PH_LOAD_HI: begin
        if ({data_byte, held_eff} == LOAD_ADDR) begin
          phase_nxt = PH_LINK_LO;
        end else begin
          cmd.ev = EV_BADADDR; phase_nxt = PH_BAD;
        end
      end
      PH_LINK_LO: begin
        held_nxt = data_byte; phase_nxt = PH_LINK_HI;
      end
      PH_LINK_HI: begin
        if (held_eff == 8'd0 && data_byte == 8'd0) begin
          cmd.ev = EV_END; phase_nxt = PH_DONE;
        end else begin
          phase_nxt = PH_NUM_LO;
        end
      end
      PH_NUM_LO: begin
        held_nxt = data_byte; phase_nxt = PH_NUM_HI;
      end
      PH_NUM_HI: begin
        cmd.src = SRC_NUM; esc_nxt = 1'b0; phase_nxt = PH_BODY;
      end
      PH_BODY: begin
        if (esc_eff) begin
          esc_nxt = 1'b0;
          cmd.src = (data_byte >= EXT_FIRST && data_byte <= EXT_LAST) ? SRC_EXT : SRC_CHAR;
        end else if (data_byte == 8'd0) begin
          cmd.ev = EV_EOL; phase_nxt = PH_LINK_LO;
        end else if (data_byte == ESC_BYTE) begin
          esc_nxt = 1'b1;
        end else if (data_byte >= STD_FIRST && data_byte <= STD_LAST) begin
          cmd.src = SRC_STD;
        end else begin
          cmd.src = SRC_CHAR;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LOAD_LO;
      held_r  <= 8'd0;
      esc_r   <= 1'b0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      esc_r   <= esc_nxt;
    end
  end

  // escape flag only lives inside a line body
  a_esc_body: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> phase_r == PH_BODY) else $error("escape outside body");
  // no new byte taken while emitting
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    sts.busy |-> !acc) else $error("accept while busy");
  a_bad_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(phase_r == PH_BAD) && !($past(acc) && $past(start_req)) |-> phase_r == PH_BAD)
    else $error("left bad state");

endmodule
`default_nettype wire

### design/bpd_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpd_dp: emit datapath
// Loads a character buffer (keyword, byte or decimal digits) and shifts it
// out one result per transaction through the output register.
// ----------------------------------------------------------------------------
module bpd_dp
  import bpd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire dp_cmd_t cmd,
  output dp_sts_t   sts,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [2:0] event_res,
  output logic [7:0] char_code,
  output logic       last
);

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_EMIT} st_t;

  st_t         st_r;
  logic [63:0] buf_r;        // chars, next out in low byte
  logic [3:0]  cnt_r;        // chars left incl. current
  logic [2:0]  ev_r;
  logic [15:0] num_r;        // remaining value during conversion
  logic [2:0]  nd_r;         // digits produced
  logic [63:0] kw;
  logic [3:0]  kw_len;
  logic [15:0] q;
  logic [3:0]  rem;
  logic [31:0] prod;

  always_comb begin
    kw = (cmd.src == SRC_STD) ? std_word(7'(cmd.byte_v - STD_FIRST))
                              : ext_word(7'(cmd.byte_v - EXT_FIRST));
    kw_len = 4'd0;
    for (int i = 0; i < MAX_CHARS; i++)
      if (kw[i*8 +: 8] != 8'd0) kw_len = 4'(i + 1);
  end

  // divide by ten via reciprocal, one digit per cycle
  assign prod = num_r * 16'hCCCD;
  assign q    = {3'd0, prod[31:19]};
  assign rem  = 4'(num_r - 16'(q * 4'd10));

  assign sts.busy  = (st_r != S_IDLE);
  assign out_valid = (st_r == S_EMIT);
  assign event_res = ev_r;
  assign char_code = buf_r[7:0];
  assign last      = (cnt_r == 4'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cnt_r <= 4'd0;
    end else begin
      case (st_r)
        S_IDLE: if (cmd.load) begin
          case (cmd.src)
            SRC_CHAR: begin
              ev_r <= EV_CHAR; buf_r <= {56'd0, cmd.byte_v}; cnt_r <= 4'd1; st_r <= S_EMIT;
            end
            SRC_STD, SRC_EXT: begin
              ev_r <= EV_CHAR; buf_r <= kw; cnt_r <= kw_len; st_r <= S_EMIT;
            end
            SRC_NUM: begin
              ev_r <= EV_CHAR; num_r <= cmd.num; nd_r <= 3'd0;
              buf_r <= {56'd0, 8'h20}; cnt_r <= 4'd1; st_r <= S_CONV;
            end
            default: begin
              ev_r <= cmd.ev; buf_r <= '0; cnt_r <= 4'd1; st_r <= S_EMIT;
            end
          endcase
        end
        S_CONV: begin
          buf_r <= {buf_r[55:0], 4'h3, rem};
          cnt_r <= cnt_r + 4'd1;
          nd_r  <= nd_r + 3'd1;
          num_r <= q;
          if (q == 16'd0 || nd_r == 3'd4) st_r <= S_EMIT;
        end
        S_EMIT: if (out_ready) begin
          buf_r <= {8'd0, buf_r[63:8]};
          cnt_r <= cnt_r - 4'd1;
          if (cnt_r == 4'd1) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != 4'd0 && cnt_r <= 4'd8) else $error("count range");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(cnt_r)) else $error("lost on stall");
  a_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ev_r != EV_CHAR |-> last) else $error("event not single");

endmodule
`default_nettype wire

### design/basic_program_detokenizer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// basic_program_detokenizer_top: tokenized BASIC file to text
// Byte stream in, character/event stream out.
// ----------------------------------------------------------------------------
// Input: in_tdata = data byte, in_tuser = start of new file (restarts parse).
// Output: out_tdata = {char_code, event_res}, out_tlast marks the final
// result of one input byte. Every byte yields at least one result.
// One byte is taken, then its results (1..8) come one per cycle from the
// output register while out_tready is high; in_tready is low until the last one is taken.
// A new byte is taken only after the last result of the previous one. The
// first result is valid in the cycle after accept, but a line number first
// passes through the divide-by-ten step, one step per decimal digit (up to 5).
// Reset clears the parse to expect a load address. A receiver stall holds
// the current result and stops input acceptance.
// ----------------------------------------------------------------------------
module basic_program_detokenizer_top
  import bpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // start_req
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [2:0] event_res, [10:3] char_code, zero fill
  output logic             out_tlast
);

  dp_cmd_t    cmd;
  dp_sts_t    sts;
  logic [2:0] ev;
  logic [7:0] ch;

  bpd_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .data_byte(in_tdata), .start_req(in_tuser), .cmd, .sts
  );

  bpd_dp u_dp (
    .clk, .rst_n, .cmd, .sts, .out_valid(out_tvalid), .out_ready(out_tready),
    .event_res(ev), .char_code(ch), .last(out_tlast)
  );

  assign out_tdata = {5'd0, ch, ev};

endmodule
`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: program detokenizer regression
// Feeds tokenized program files (well-formed, broken, noise) with random
// gaps and output stalls, predicts the text stream and checks every result.
// ----------------------------------------------------------------------------
module testbench;
  import bpd_pkg::*;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
  } file_byte_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] char_code;
    logic       last;
  } text_item_t;

  localparam logic [3:0] PH_LOAD_LO = 4'd0, PH_LOAD_HI = 4'd1, PH_LINK_LO = 4'd2,
                         PH_LINK_HI = 4'd3, PH_NUM_LO = 4'd4, PH_NUM_HI = 4'd5,
                         PH_BODY = 4'd6, PH_DONE = 4'd7, PH_BAD = 4'd8;

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tuser;
  logic [7:0] in_tdata;
  logic out_tvalid, out_tready, out_tlast;
  logic [15:0] out_tdata;

  basic_program_detokenizer_top DUT (.*);

  file_byte_t  pending_bytes[$];
  text_item_t  expected_text[$];
  int          error_count = 0;
  int          cycle_count = 0;
  bit          stimulus_done = 0;

  // predictor state
  logic [3:0] phase;
  logic [7:0] held_lo;
  logic       esc_pending;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  function automatic void push_word(input logic [63:0] w);
    text_item_t t;
    for (int i = 0; i < 8; i++) begin
      if (w[i*8 +: 8] == 8'd0) break;
      t = '{EV_CHAR, w[i*8 +: 8], 1'b0};
      expected_text = {expected_text, t};
    end
  endfunction

  function automatic void push_event(input logic [2:0] ev, input logic [7:0] ch);
    text_item_t t;
    t = '{ev, ch, 1'b0};
    expected_text = {expected_text, t};
  endfunction

  // keyword spellings come from the package tables (data, not logic)
  function automatic void predict_text(input file_byte_t fb);
    int n0;
    int v;
    logic [7:0] digits[$];
    logic [7:0] b;
    b = fb.data_byte;
    n0 = expected_text.size();
    if (fb.start_req) begin
      phase = PH_LOAD_LO;
      held_lo = 0;
      esc_pending = 0;
    end
    case (phase)
      PH_LOAD_LO: begin held_lo = b; phase = PH_LOAD_HI; end
      PH_LOAD_HI: begin
        if ({b, held_lo} == LOAD_ADDR) phase = PH_LINK_LO;
        else begin push_event(EV_BADADDR, 0); phase = PH_BAD; end
      end
      PH_LINK_LO: begin held_lo = b; phase = PH_LINK_HI; end
      PH_LINK_HI: begin
        if (held_lo == 0 && b == 0) begin push_event(EV_END, 0); phase = PH_DONE; end
        else phase = PH_NUM_LO;
      end
      PH_NUM_LO: begin held_lo = b; phase = PH_NUM_HI; end
      PH_NUM_HI: begin
        v = {b, held_lo};
        do begin
          digits.push_front(8'(8'h30 + v % 10));
          v = v / 10;
        end while (v != 0);
        foreach (digits[i]) push_event(EV_CHAR, digits[i]);
        push_event(EV_CHAR, 8'h20);
        esc_pending = 0;
        phase = PH_BODY;
      end
      PH_BODY: begin
        if (esc_pending) begin
          esc_pending = 0;
          if (b >= EXT_FIRST && b <= EXT_LAST) push_word(ext_word(7'(b - EXT_FIRST)));
          else push_event(EV_CHAR, b);
        end else if (b == 0) begin
          push_event(EV_EOL, 0);
          phase = PH_LINK_LO;
        end else if (b == ESC_BYTE) esc_pending = 1;
        else if (b >= STD_FIRST && b <= STD_LAST) push_word(std_word(7'(b - STD_FIRST)));
        else push_event(EV_CHAR, b);
      end
      default: ;
    endcase
    if (expected_text.size() == n0) push_event(EV_NONE, 0);
    expected_text[$].last = 1'b1;
  endfunction

  function automatic void add_byte(input logic [7:0] b, input logic s = 0);
    file_byte_t fb;
    fb = '{b, s};
    pending_bytes = {pending_bytes, fb};
  endfunction

  // random body byte, biased toward tokens and prefixes
  function automatic logic [7:0] body_byte();
    case ($urandom_range(0, 5))
      0, 1: return 8'($urandom_range(STD_FIRST, STD_LAST));
      2: return ESC_BYTE;
      3: return 8'($urandom_range(1, 255));
      4: return 8'($urandom_range(8'h20, 8'h5F));
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic void add_file(input bit broken);
    int lines, len;
    logic [15:0] num;
    add_byte(8'h01, 1);
    if (broken && $urandom_range(0, 1)) add_byte(8'($urandom));
    else add_byte(8'h08);
    lines = $urandom_range(1, 4);
    for (int l = 0; l < lines; l++) begin
      add_byte(8'($urandom)); add_byte(8'($urandom_range(1, 255)));
      num = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 999));
      add_byte(num[7:0]); add_byte(num[15:8]);
      len = $urandom_range(0, 8);
      for (int i = 0; i < len; i++) add_byte(body_byte());
      add_byte(8'h00);
    end
    if (!broken) begin
      add_byte(0); add_byte(0);
    end
    // trailing bytes after end or bad address yield only an EV_NONE result
    for (int i = $urandom_range(0, 2); i > 0; i--) add_byte(8'($urandom));
  endfunction

  // driver
  int in_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
      in_tdata <= 0;
      in_tuser <= 0;
      in_gap <= 0;
    end else if (in_tvalid && !in_tready) begin
    end else if (in_gap > 0) begin
      in_tvalid <= 0;
      in_gap <= in_gap - 1;
    end else if (pending_bytes.size() > 0) begin
      file_byte_t fb;
      fb = pending_bytes.pop_front();
      predict_text(fb);
      in_tvalid <= 1;
      in_tdata <= fb.data_byte;
      in_tuser <= fb.start_req;
      in_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
    end else begin
      in_tvalid <= 0;
      stimulus_done <= 1;
    end
  end

  // monitor
  int out_wait;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      out_tready <= 0;
      out_wait <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        text_item_t exp_t;
        if (expected_text.size() == 0) report_mismatch("result with none expected");
        else begin
          exp_t = expected_text.pop_front();
          if (out_tdata[2:0] !== exp_t.event_res)
            report_mismatch($sformatf("event %0d exp %0d", out_tdata[2:0], exp_t.event_res));
          if (out_tdata[10:3] !== exp_t.char_code)
            report_mismatch($sformatf("char %h exp %h", out_tdata[10:3], exp_t.char_code));
          if (out_tlast !== exp_t.last)
            report_mismatch($sformatf("last %b exp %b", out_tlast, exp_t.last));
        end
        out_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
        out_tready <= 0;
      end else if (out_wait > 0) begin
        out_wait <= out_wait - 1;
        out_tready <= 0;
      end else out_tready <= 1;
    end
  end

  initial begin
    int tail;
    phase = PH_LOAD_LO; held_lo = 0; esc_pending = 0;
    rst_n = 0;
    in_tvalid = 0; in_tdata = 0; in_tuser = 0; out_tready = 0;
    // directed: extremes, every keyword kind, prefix corner cases, bad address
    add_byte(8'h01, 1); add_byte(8'h08);
    add_byte(8'hFF); add_byte(8'hFF); add_byte(8'hFF); add_byte(8'hFF);
    add_byte(STD_FIRST); add_byte(STD_LAST); add_byte(ESC_BYTE); add_byte(EXT_FIRST);
    add_byte(ESC_BYTE); add_byte(EXT_LAST); add_byte(ESC_BYTE); add_byte(8'h00);
    add_byte(ESC_BYTE); add_byte(8'hFF); add_byte(8'h7F); add_byte(8'h00);
    add_byte(8'h01); add_byte(8'h00); add_byte(8'h00); add_byte(8'h00); add_byte(8'h00);
    add_byte(0); add_byte(0); add_byte(8'hAA);
    add_byte(8'hFF, 1); add_byte(8'hFF); add_byte(8'h55);
    while (pending_bytes.size() < 460) begin
      if ($urandom_range(0, 9) == 0) begin
        add_byte(8'($urandom), 1);
        for (int i = $urandom_range(0, 4); i > 0; i--) add_byte(8'($urandom), 1'($urandom));
      end else add_file($urandom_range(0, 7) == 0);
    end
    repeat (3) @(posedge clk);
    rst_n <= 1;
    while (!(stimulus_done && expected_text.size() == 0) && cycle_count < 200000)
      @(posedge clk);
    tail = 0;
    while (tail < 20) begin
      @(posedge clk);
      tail++;
    end
    if (cycle_count >= 200000) begin
      $display("[FAIL] regression broken");
      $finish;
    end else if (error_count == 0 && expected_text.size() == 0) begin
      $display("[ OK ] regression clean");
      $finish;
    end else begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule

### sim.f
design/bpd_pkg.sv
design/bpd_ctrl.sv
design/bpd_dp.sv
design/basic_program_detokenizer_top.sv
dv/testbench.sv
